@@ src/lsra_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear-scan register allocator package
// Shared widths, default parameter values and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lsra_pkg;

   // Field widths of the request and response words.
   localparam int ID_W  = 16;
   localparam int POS_W = 16;
   localparam int REG_W = 4;
   localparam int CNT_W = 16;

   // Default configuration of the register file.
   localparam int DEF_NUM_REGS  = 7;
   localparam int DEF_FIRST_REG = 4;

   // Commands from the controller to the datapath, at most one step a cycle.
   typedef struct packed {
      logic load;        // Capture the request word, apply the start-of-pass clear.
      logic expire;      // Free every active entry that ended before the new start.
      logic admit_free;  // Give the lowest free register to the new interval.
      logic scan_init;   // No register is free: start the eviction search.
      logic scan_step;   // Compare one active entry against the best so far.
      logic decide;      // Evict the best candidate or spill the new interval.
      logic publish;     // Move the finished result into the output register.
   } lsra_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic any_free;    // At least one register is free.
      logic scan_last;   // The search is looking at the last slot.
   } lsra_status_type;

endpackage

@@ src/linear_scan_register_allocator.sv @@
// ----------------------------------------------------------------------------
// Linear-scan register allocator
// Gives each live interval a register, evicting or spilling when full.
// ----------------------------------------------------------------------------
// Usage:
//   Live intervals arrive on the req_ channel in ascending start order, one
//   word each; a word is taken when req_valid is high and req_stall is low.
//   Each word yields exactly one rsp_ word: the register given, a self-spill
//   flag, the evicted interval if any, and a sticky pass-failure flag.
//   req_first_of_pass clears the active set before its interval is handled.
//   Timing: one interval is handled at a time. With a free register the
//   word goes through expiry and allocation and is published once the
//   output register is free; the next word is taken after the publish.
//   With all registers busy, the eviction search walks one slot per cycle.
//   The output register holds a finished word while rsp_stall is high; the
//   block may accept the next interval meanwhile, and waits only to publish.
//   Reset (synchronous) empties the active set, frees all registers, clears
//   the admit counter and the failure flag and drops rsp_valid.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator #(
   parameter int NUM_REGS  = lsra_pkg::DEF_NUM_REGS,
   parameter int FIRST_REG = lsra_pkg::DEF_FIRST_REG
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_first_of_pass,
   input  logic [lsra_pkg::ID_W-1:0]  req_interval_id,
   input  logic [lsra_pkg::POS_W-1:0] req_interval_start,
   input  logic [lsra_pkg::POS_W-1:0] req_interval_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lsra_pkg::REG_W-1:0] rsp_assigned_reg,
   output logic                       rsp_self_spilled,
   output logic                       rsp_evicted_valid,
   output logic [lsra_pkg::ID_W-1:0]  rsp_evicted_id,
   output logic                       rsp_pass_failed
);
   import lsra_pkg::*;

   lsra_cmd_type    cmd;
   lsra_status_type status;

   // Sequencer.
   lsra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Active set and result path.
   lsra_dpath #(
      .NUM_REGS  (NUM_REGS),
      .FIRST_REG (FIRST_REG)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_first_of_pass  (req_first_of_pass),
      .req_interval_id    (req_interval_id),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .rsp_assigned_reg   (rsp_assigned_reg),
      .rsp_self_spilled   (rsp_self_spilled),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_id     (rsp_evicted_id),
      .rsp_pass_failed    (rsp_pass_failed)
   );

endmodule

@@ src/lsra_dpath.sv @@
// ----------------------------------------------------------------------------
// Linear-scan register allocator datapath
// Active set, free detection, one-slot-a-cycle eviction search, result and
// output registers. Every step is started by a command from the controller.
// ----------------------------------------------------------------------------
module lsra_dpath #(
   parameter int NUM_REGS  = lsra_pkg::DEF_NUM_REGS,
   parameter int FIRST_REG = lsra_pkg::DEF_FIRST_REG
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lsra_pkg::lsra_cmd_type         cmd,
   output lsra_pkg::lsra_status_type      status,
   input  logic                           req_first_of_pass,
   input  logic [lsra_pkg::ID_W-1:0]      req_interval_id,
   input  logic [lsra_pkg::POS_W-1:0]     req_interval_start,
   input  logic [lsra_pkg::POS_W-1:0]     req_interval_end,
   output logic [lsra_pkg::REG_W-1:0]     rsp_assigned_reg,
   output logic                           rsp_self_spilled,
   output logic                           rsp_evicted_valid,
   output logic [lsra_pkg::ID_W-1:0]      rsp_evicted_id,
   output logic                           rsp_pass_failed
);
   import lsra_pkg::*;

   localparam int SLOT_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   // Active set: one entry per physical register.
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [POS_W-1:0]    entry_end_ff [NUM_REGS];
   logic [ID_W-1:0]     entry_id_ff  [NUM_REGS];
   logic [CNT_W-1:0]    entry_age_ff [NUM_REGS];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                failed_ff, failed_in;

   // Captured request word.
   logic [ID_W-1:0]     req_id_ff;
   logic [POS_W-1:0]    req_start_ff;
   logic [POS_W-1:0]    req_end_ff;

   // Eviction search registers.
   logic [SLOT_W-1:0]   scan_idx_ff;
   logic [SLOT_W-1:0]   best_slot_ff;
   logic [POS_W-1:0]    best_end_ff;
   logic [CNT_W-1:0]    best_dist_ff;

   // Finished result, then the output register.
   logic [REG_W-1:0]    res_reg_ff;
   logic                res_self_ff;
   logic                res_evict_ff;
   logic [ID_W-1:0]     res_evid_ff;
   logic [REG_W-1:0]    out_reg_ff;
   logic                out_self_ff;
   logic                out_evict_ff;
   logic [ID_W-1:0]     out_evid_ff;
   logic                out_failed_ff;

   logic [SLOT_W-1:0]   free_slot;
   logic [POS_W-1:0]    scan_end;
   logic [CNT_W-1:0]    scan_dist;
   logic                scan_better;
   logic                evict;
   logic                admit_en;
   logic [SLOT_W-1:0]   admit_slot;

   // Lowest-numbered free slot.
   always_comb begin
      free_slot = '0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   // One entry of the search: larger end wins, ties go to the latest admitted.
   assign scan_end    = entry_end_ff[scan_idx_ff];
   assign scan_dist   = count_ff - entry_age_ff[scan_idx_ff];
   assign scan_better = (scan_idx_ff == '0) || (scan_end > best_end_ff) ||
                        ((scan_end == best_end_ff) && (scan_dist < best_dist_ff));

   // The candidate is evicted only when it lives longer than the new interval.
   assign evict      = best_end_ff > req_end_ff;
   assign admit_en   = cmd.admit_free || (cmd.decide && evict);
   assign admit_slot = cmd.admit_free ? free_slot : best_slot_ff;

   assign status.any_free  = ~&valid_ff;
   assign status.scan_last = scan_idx_ff == SLOT_W'(NUM_REGS - 1);

   // Next value of the valid bits, the admit counter and the failure flag.
   always_comb begin
      valid_in  = valid_ff;
      count_in  = count_ff;
      failed_in = failed_ff;
      if (cmd.load && req_first_of_pass) begin
         valid_in  = '0;
         count_in  = '0;
         failed_in = 1'b0;
      end
      if (cmd.expire) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (valid_ff[i] && (entry_end_ff[i] < req_start_ff)) begin
               valid_in[i] = 1'b0;
            end
         end
      end
      if (admit_en) begin
         valid_in[admit_slot] = 1'b1;
         count_in             = count_ff + CNT_W'(1);
      end
      if (cmd.scan_init) begin
         failed_in = 1'b1;
      end
   end

   // Control state of the active set.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         failed_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         failed_ff <= failed_in;
      end
   end

   // Entry payload, written when an interval is admitted.
   always_ff @(posedge clock) begin
      if (admit_en) begin
         entry_end_ff[admit_slot] <= req_end_ff;
         entry_id_ff[admit_slot]  <= req_id_ff;
         entry_age_ff[admit_slot] <= count_ff;
      end
   end

   // Request capture and the eviction search.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_id_ff    <= req_interval_id;
         req_start_ff <= req_interval_start;
         req_end_ff   <= req_interval_end;
      end
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
         if (scan_better) begin
            best_slot_ff <= scan_idx_ff;
            best_end_ff  <= scan_end;
            best_dist_ff <= scan_dist;
         end
      end
   end

   // Result of the current interval.
   always_ff @(posedge clock) begin
      if (cmd.admit_free) begin
         res_reg_ff   <= REG_W'(FIRST_REG) + REG_W'(free_slot);
         res_self_ff  <= 1'b0;
         res_evict_ff <= 1'b0;
         res_evid_ff  <= '0;
      end else if (cmd.decide) begin
         if (evict) begin
            res_reg_ff   <= REG_W'(FIRST_REG) + REG_W'(best_slot_ff);
            res_self_ff  <= 1'b0;
            res_evict_ff <= 1'b1;
            res_evid_ff  <= entry_id_ff[best_slot_ff];
         end else begin
            res_reg_ff   <= '0;
            res_self_ff  <= 1'b1;
            res_evict_ff <= 1'b0;
            res_evid_ff  <= '0;
         end
      end
   end

   // Output register, held while the receiver stalls.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_reg_ff    <= res_reg_ff;
         out_self_ff   <= res_self_ff;
         out_evict_ff  <= res_evict_ff;
         out_evid_ff   <= res_evid_ff;
         out_failed_ff <= failed_ff;
      end
   end

   assign rsp_assigned_reg  = out_reg_ff;
   assign rsp_self_spilled  = out_self_ff;
   assign rsp_evicted_valid = out_evict_ff;
   assign rsp_evicted_id    = out_evid_ff;
   assign rsp_pass_failed   = out_failed_ff;

endmodule

@@ src/lsra_ctrl.sv @@
// ----------------------------------------------------------------------------
// Linear-scan register allocator controller
// Sequences one interval at a time through expiry, allocation, the eviction
// search and the output handshake.
// ----------------------------------------------------------------------------
module lsra_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lsra_pkg::lsra_cmd_type    cmd,
   input  lsra_pkg::lsra_status_type status
);
   import lsra_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXPIRE = 3'd1;
   localparam logic [2:0] S_ALLOC  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The output register can take a word when empty or being emptied.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXPIRE;
            end
         end
         S_EXPIRE: begin
            cmd.expire = 1'b1;
            state_in   = S_ALLOC;
         end
         S_ALLOC: begin
            if (status.any_free) begin
               cmd.admit_free = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set by a publish, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ test/lsra_allocation_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation checker for the linear-scan register allocator
// Watches the request and response channels, keeps its own copy of the
// active set, predicts the response word for every accepted interval and
// compares each response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lsra_allocation_checker #(
   parameter int NUM_REGS  = lsra_pkg::DEF_NUM_REGS,
   parameter int FIRST_REG = lsra_pkg::DEF_FIRST_REG
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_first_of_pass,
   input  logic [lsra_pkg::ID_W-1:0]  req_interval_id,
   input  logic [lsra_pkg::POS_W-1:0] req_interval_start,
   input  logic [lsra_pkg::POS_W-1:0] req_interval_end,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [lsra_pkg::REG_W-1:0] rsp_assigned_reg,
   input  logic                       rsp_self_spilled,
   input  logic                       rsp_evicted_valid,
   input  logic [lsra_pkg::ID_W-1:0]  rsp_evicted_id,
   input  logic                       rsp_pass_failed,
   output int                         fail_count,
   output int                         pending_words,
   output int                         words_checked
);
   import lsra_pkg::*;

   // One predicted response word.
   typedef struct packed {
      logic [REG_W-1:0] assigned_reg;
      logic             self_spilled;
      logic             evicted_valid;
      logic [ID_W-1:0]  evicted_id;
      logic             pass_failed;
   } alloc_word_type;

   // Shadow copy of the active set and the pass state.
   logic             slot_busy   [NUM_REGS];
   logic [POS_W-1:0] slot_end    [NUM_REGS];
   logic [ID_W-1:0]  slot_owner  [NUM_REGS];
   logic [CNT_W-1:0] slot_stamp  [NUM_REGS];
   logic [CNT_W-1:0] admit_count;
   logic             spill_seen;

   alloc_word_type predicted_words[$];
   alloc_word_type oldest;
   int             fails   = 0;
   int             checked = 0;

   // Empty the active set and start a new pass.
   function void clear_active_set();
      int i;
      for (i = 0; i < NUM_REGS; i++) begin
         slot_busy[i]  = 1'b0;
         slot_end[i]   = '0;
         slot_owner[i] = '0;
         slot_stamp[i] = '0;
      end
      admit_count = '0;
      spill_seen  = 1'b0;
   endfunction

   // Hand a slot to an interval and stamp it with the admit count.
   function void occupy_slot(input int slot, input logic [ID_W-1:0] owner,
                             input logic [POS_W-1:0] last_use);
      slot_busy[slot]  = 1'b1;
      slot_end[slot]   = last_use;
      slot_owner[slot] = owner;
      slot_stamp[slot] = admit_count;
      admit_count      = admit_count + 1'b1;
   endfunction

   // Work out the allocation for one interval and update the shadow state.
   function automatic alloc_word_type allocate_interval(input logic fresh_pass,
                                                        input logic [ID_W-1:0] owner,
                                                        input logic [POS_W-1:0] start,
                                                        input logic [POS_W-1:0] last_use);
      alloc_word_type   word;
      int               i;
      int               slot;
      int               victim;
      logic [POS_W-1:0] victim_end;
      logic [CNT_W-1:0] victim_dist;
      logic [CNT_W-1:0] age_gap;
      word        = '0;
      slot        = -1;
      victim      = -1;
      victim_end  = '0;
      victim_dist = '0;
      if (fresh_pass)
         clear_active_set();
      // Expire every entry that ended before the new start.
      for (i = 0; i < NUM_REGS; i++)
         if (slot_busy[i] && slot_end[i] < start)
            slot_busy[i] = 1'b0;
      // The lowest free slot wins.
      for (i = 0; i < NUM_REGS; i++)
         if (!slot_busy[i] && slot < 0)
            slot = i;
      if (slot >= 0) begin
         occupy_slot(slot, owner, last_use);
         word.assigned_reg = REG_W'(FIRST_REG + slot);
      end else begin
         // Largest end; among equal ends the most recent admission.
         for (i = 0; i < NUM_REGS; i++) begin
            if (slot_busy[i]) begin
               age_gap = admit_count - slot_stamp[i];
               if (victim < 0 || slot_end[i] > victim_end ||
                   (slot_end[i] == victim_end && age_gap < victim_dist)) begin
                  victim      = i;
                  victim_end  = slot_end[i];
                  victim_dist = age_gap;
               end
            end
         end
         if (victim >= 0 && victim_end > last_use) begin
            word.evicted_valid = 1'b1;
            word.evicted_id    = slot_owner[victim];
            occupy_slot(victim, owner, last_use);
            word.assigned_reg  = REG_W'(FIRST_REG + victim);
         end else begin
            word.self_spilled = 1'b1;
         end
         spill_seen = 1'b1;
      end
      word.pass_failed = spill_seen;
      return word;
   endfunction

   // Report one field that differs from the prediction.
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   // Predict on every accepted request word, compare every accepted response word.
   always @(posedge clock) begin
      if (reset) begin
         clear_active_set();
         predicted_words.delete();
      end else begin
         if (req_valid && !req_stall)
            predicted_words = {predicted_words,
                               allocate_interval(req_first_of_pass, req_interval_id,
                                                 req_interval_start, req_interval_end)};
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               $display("%0t: response word with no interval pending, expected none, actual reg %0h",
                        $time, rsp_assigned_reg);
               fails++;
            end else begin
               oldest = predicted_words.pop_front();
               checked++;
               check_field("assigned_reg", 16'(oldest.assigned_reg), 16'(rsp_assigned_reg));
               check_field("self_spilled", 16'(oldest.self_spilled), 16'(rsp_self_spilled));
               check_field("evicted_valid", 16'(oldest.evicted_valid),
                           16'(rsp_evicted_valid));
               check_field("evicted_id", oldest.evicted_id, rsp_evicted_id);
               check_field("pass_failed", 16'(oldest.pass_failed), 16'(rsp_pass_failed));
            end
         end
      end
      fail_count    <= fails;
      pending_words <= predicted_words.size();
      words_checked <= checked;
   end

endmodule

@@ test/linear_scan_register_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear-scan register allocator testbench
// Drives live intervals into the allocator: a directed sequence for full
// sets, evictions, self spills, equal ends and expiry, then random passes
// with random idling on both channels, equal ends at the top of the
// position range, and a final stretch without idling. The allocation
// checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_tb;
   import lsra_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DIRECTED_WORDS = 24;
   localparam int RANDOM_WORDS   = 1165;
   localparam int CALM_WORDS     = 150;
   localparam int DRAIN_CYCLES   = 20;

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             req_valid          = 1'b0;
   logic             req_first_of_pass  = 1'b0;
   logic [ID_W-1:0]  req_interval_id    = '0;
   logic [POS_W-1:0] req_interval_start = '0;
   logic [POS_W-1:0] req_interval_end   = '0;
   logic             rsp_stall          = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   logic [REG_W-1:0] rsp_assigned_reg;
   logic             rsp_self_spilled;
   logic             rsp_evicted_valid;
   logic [ID_W-1:0]  rsp_evicted_id;
   logic             rsp_pass_failed;

   int   fail_count;
   int   pending_words;
   int   words_checked;
   int   sent_words   = 0;
   int   pass_count   = 0;
   int   quiet_cycles = 0;
   int   stall_left   = 0;
   logic stall_on     = 1'b0;
   bit   gaps_on      = 1'b0;

   always #1 clock = ~clock;

   linear_scan_register_allocator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_of_pass  (req_first_of_pass),
      .req_interval_id    (req_interval_id),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_assigned_reg   (rsp_assigned_reg),
      .rsp_self_spilled   (rsp_self_spilled),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_id     (rsp_evicted_id),
      .rsp_pass_failed    (rsp_pass_failed)
   );

   lsra_allocation_checker monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_of_pass  (req_first_of_pass),
      .req_interval_id    (req_interval_id),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_assigned_reg   (rsp_assigned_reg),
      .rsp_self_spilled   (rsp_self_spilled),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_id     (rsp_evicted_id),
      .rsp_pass_failed    (rsp_pass_failed),
      .fail_count         (fail_count),
      .pending_words      (pending_words),
      .words_checked      (words_checked)
   );

   // Response stall comes in random bursts while idling is on.
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 11) == 0)
            stall_left <= $urandom_range(1, 17);
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one interval word and hold it until it is taken.
   task automatic send_word(input logic fresh, input logic [ID_W-1:0] owner,
                            input logic [POS_W-1:0] start, input logic [POS_W-1:0] last_use);
      req_valid          <= 1'b1;
      req_first_of_pass  <= fresh;
      req_interval_id    <= owner;
      req_interval_start <= start;
      req_interval_end   <= last_use;
      do @(posedge clock); while (req_stall);
      sent_words++;
      if (fresh)
         pass_count++;
   endtask

   // Sometimes leave the request channel idle for a burst.
   task automatic maybe_pause();
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic set_idling(input bit on);
      gaps_on   = on;
      stall_on <= on;
   endtask

   // One pass of intervals in ascending start order with a random lifetime style.
   task automatic run_pass(input int len, input bit fresh);
      int k;
      int pos;
      int last;
      int style;
      int tie_end;
      pos     = $urandom_range(0, 65535 - 4 * len);
      style   = $urandom_range(0, 3);
      tie_end = pos + $urandom_range(8, 300);
      for (k = 0; k < len; k++) begin
         if (k > 0)
            pos = pos + $urandom_range(0, 3);
         case (style)
            0:       last = pos + $urandom_range(0, 8);
            1:       last = pos + $urandom_range(0, 80);
            2:       last = pos + $urandom_range(0, 5000);
            default: last = ($urandom_range(0, 3) == 0) ? pos + $urandom_range(0, 40) : tie_end;
         endcase
         // An occasional end anywhere, often below the start.
         if ($urandom_range(0, 24) == 0)
            last = $urandom_range(0, 65535);
         if (last > 65535)
            last = 65535;
         send_word(fresh && k == 0, 16'($urandom), 16'(pos), 16'(last));
         maybe_pause();
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int k;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_idling(1'b1);

      // Fill all seven registers, evict the longest, then take registers freed by expiry.
      send_word(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
      maybe_pause();
      for (k = 1; k <= 6; k++) begin
         send_word(1'b0, 16'(k), 16'((k + 1) / 2), 16'(10 * k));
         maybe_pause();
      end
      send_word(1'b0, 16'd7, 16'd7, 16'd5);
      send_word(1'b0, 16'd8, 16'd8, 16'hFFFF);
      send_word(1'b0, 16'd9, 16'd15, 16'd0);
      maybe_pause();

      // Equal ends: the latest admission goes first; an equal new end spills itself.
      for (k = 0; k < 7; k++) begin
         send_word(k == 0, 16'(16'h8000 + k), 16'(100 + k), 16'd500);
         maybe_pause();
      end
      send_word(1'b0, 16'h0100, 16'd107, 16'd200);
      send_word(1'b0, 16'h0101, 16'd108, 16'd200);
      send_word(1'b0, 16'h0102, 16'd109, 16'd500);
      send_word(1'b0, 16'h0103, 16'd600, 16'd700);
      maybe_pause();

      // Extremes of the fields and a new pass that clears the failure flag.
      send_word(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_word(1'b0, 16'h5555, 16'hFFFF, 16'h0000);
      send_word(1'b0, 16'hAAAA, 16'hFFFF, 16'hFFFF);
      maybe_pause();

      // Random passes, some continuing the previous pass, mixed with noise.
      while (sent_words < DIRECTED_WORDS + RANDOM_WORDS) begin
         set_idling($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 6) == 0) begin
            burst = $urandom_range(1, 8);
            for (k = 0; k < burst; k++) begin
               send_word($urandom_range(0, 7) == 0, 16'($urandom), 16'($urandom),
                         16'($urandom));
               maybe_pause();
            end
         end else begin
            run_pass($urandom_range(1, 40), $urandom_range(0, 9) != 0);
         end
      end

      // Equal ends at the top of the position range.
      set_idling(1'b1);
      for (k = 0; k < 7; k++) begin
         send_word(1'b0, 16'($urandom), 16'd65534, 16'd65535);
         maybe_pause();
      end
      for (k = 0; k < 8; k++) begin
         send_word(1'b0, 16'($urandom), 16'd65534, 16'd65534);
         maybe_pause();
      end

      // Final stretch with no idling on either side.
      set_idling(1'b0);
      burst = sent_words + CALM_WORDS;
      while (sent_words < burst)
         run_pass($urandom_range(1, 40), 1'b1);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d interval words in %0d passes, with idling, evictions, self spills",
               sent_words, pass_count);
      $display("and equal ends; %0d response words were checked.", words_checked);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/lsra_pkg.sv
src/lsra_dpath.sv
src/lsra_ctrl.sv
src/linear_scan_register_allocator.sv
test/lsra_allocation_checker.sv
test/linear_scan_register_allocator_tb.sv
